// ===== src/amtm_pkg.sv =====
// Package: shared widths, constants and interface structs of the median / trimmed-mean filter.
package amtm_pkg;

   // Field widths of the stream payloads
   localparam int SAMPLE_W = 12;
   localparam int CHAN_W   = 4;
   localparam int REQ_DATA_W = 16;   // sample, channel
   localparam int RSP_DATA_W = 24;   // median, average

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 12'hFFF;
   localparam logic [CHAN_W-1:0]   CHAN_SEL_RESET = 4'd2;

   // Median queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic                full;
      logic                empty;
   } queue_status_type;

   typedef struct packed {
      logic                valid;
      logic [SAMPLE_W-1:0] median;
   } median_push_type;

endpackage

// ===== src/amtm_front.sv =====
// Front end: channel select register, sorted insertion cells and lower median at frame end.
module amtm_front import amtm_pkg::*; #(
   parameter int ADD_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] sample, [15:12] channel
   input  logic                  req_tlast,   // frame_end
   input  logic                  req_tuser,   // discard_frame
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CHAN_W-1:0]     csr_data,    // channel_select
   input  queue_status_type      q_status,
   output median_push_type       push
);

   localparam int CNT_W = $clog2(ADD_COUNT + 1);
   localparam int IDX_W = (ADD_COUNT > 1) ? $clog2(ADD_COUNT) : 1;

   logic [CHAN_W-1:0]   chan_sel_ff, chan_sel_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SAMPLE_W-1:0] cell_ff [ADD_COUNT];
   logic [SAMPLE_W-1:0] cell_in [ADD_COUNT];
   logic [ADD_COUNT-1:0] gt;
   logic [SAMPLE_W-1:0] sample;
   logic [CNT_W-1:0]    cnt_next;
   logic [CNT_W-1:0]    mid_wide;
   logic [IDX_W-1:0]    mid_idx;
   logic                accept;
   logic                keep;

   assign sample     = req_tdata[SAMPLE_W-1:0];
   assign req_tready = !q_status.full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign keep       = (req_tdata[REQ_DATA_W-1:SAMPLE_W] == chan_sel_ff)
                       && (count_ff < CNT_W'(ADD_COUNT));

   // Compare new sample against every occupied cell (cells are ascending)
   always_comb begin
      for (int i = 0; i < ADD_COUNT; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (cell_ff[i] > sample);
      end
   end

   // Shift larger cells up by one and drop the sample into the gap
   always_comb begin
      for (int i = 0; i < ADD_COUNT; i++) begin
         if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
         end else if (gt[i] || CNT_W'(i) == count_ff) begin
            cell_in[i] = sample;
         end else begin
            cell_in[i] = cell_ff[i];
         end
      end
   end

   // Kept count after this item and the lower-median index
   assign cnt_next = keep ? count_ff + CNT_W'(1) : count_ff;
   assign mid_wide = (cnt_next - CNT_W'(1)) >> 1;
   assign mid_idx  = mid_wide[IDX_W-1:0];

   // Push a median at a frame end that has samples and is not discarded
   always_comb begin
      push.valid  = accept && req_tlast && !req_tuser && (cnt_next != '0);
      push.median = keep ? cell_in[mid_idx] : cell_ff[mid_idx];
   end

   // Next count and channel select
   always_comb begin
      count_in    = count_ff;
      chan_sel_in = chan_sel_ff;
      if (accept) begin
         count_in = req_tlast ? '0 : cnt_next;
      end
      if (csr_valid && csr_ready) begin
         chan_sel_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         chan_sel_ff <= CHAN_SEL_RESET;
      end else begin
         count_ff    <= count_in;
         chan_sel_ff <= chan_sel_in;
      end
   end

   // Cells hold payload only
   always_ff @(posedge clock) begin
      if (accept && keep) begin
         for (int i = 0; i < ADD_COUNT; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

endmodule

// ===== src/amtm_queue.sv =====
// Short median queue between the front end and the back end.
module amtm_queue import amtm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  median_push_type     push,
   input  logic                pop,
   output logic [SAMPLE_W-1:0] pop_median,
   output queue_status_type    q_status
);

   logic [SAMPLE_W-1:0]  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   fill_ff, fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign q_status.full  = (fill_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign q_status.empty = (fill_ff == '0);
   assign do_push        = push.valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_median     = mem_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.median;
      end
   end

endmodule

// ===== src/amtm_back.sv =====
// Back end: running sum/min/max of medians, reciprocal-multiply trimmed mean, result register.
module amtm_back import amtm_pkg::*; #(
   parameter int AVG_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      q_status,
   input  logic [SAMPLE_W-1:0]   pop_median,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] median, [23:12] average
   output logic                  rsp_tuser    // average_valid
);

   localparam int SUM_W   = SAMPLE_W + $clog2(AVG_COUNT + 1);
   localparam int MCNT_W  = $clog2(AVG_COUNT);
   localparam int DIV_N   = AVG_COUNT - 2;
   // floor(x / DIV_N) == (x * RECIP) >> SHIFT for every x below 2**SUM_W
   localparam int SHIFT   = SUM_W + $clog2(DIV_N);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(DIV_N) - 64'd1) / 64'(DIV_N));

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TRIM = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] min_ff, min_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [MCNT_W-1:0]   mcnt_ff, mcnt_in;
   logic [SAMPLE_W-1:0] med_hold_ff, med_hold_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic                out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                out_flag_ff, out_flag_in;
   logic                out_free;
   logic [PROD_W-1:0]   product;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign pop        = (state_ff == ST_IDLE) && !q_status.empty && out_free;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_flag_ff;

   // Trimmed sum times the reciprocal of the divisor
   assign product = PROD_W'(quo_ff) * PROD_W'(RECIP);

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mcnt_in      = mcnt_ff;
      med_hold_in  = med_hold_ff;
      quo_in       = quo_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_flag_in  = out_flag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // Fold the median into the running set
            if (pop) begin
               sum_in      = sum_ff + SUM_W'(pop_median);
               min_in      = (pop_median < min_ff) ? pop_median : min_ff;
               max_in      = (pop_median > max_ff) ? pop_median : max_ff;
               med_hold_in = pop_median;
               if (mcnt_ff == MCNT_W'(AVG_COUNT - 1)) begin
                  mcnt_in  = '0;
                  state_in = ST_TRIM;
               end else begin
                  mcnt_in      = mcnt_ff + MCNT_W'(1);
                  out_valid_in = 1'b1;
                  out_data_in  = {{SAMPLE_W{1'b0}}, pop_median};
                  out_flag_in  = 1'b0;
               end
            end
         end
         ST_TRIM: begin
            // Drop min and max, restart the set
            quo_in   = sum_ff - SUM_W'(min_ff) - SUM_W'(max_ff);
            sum_in   = '0;
            min_in   = SAMPLE_MAX;
            max_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Take the quotient from the upper product bits
            quo_in   = SUM_W'(product[SHIFT +: SAMPLE_W]);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hold until the result register is free
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {quo_ff[SAMPLE_W-1:0], med_hold_ff};
               out_flag_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         min_ff       <= SAMPLE_MAX;
         max_ff       <= '0;
         mcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         mcnt_ff      <= mcnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      med_hold_ff <= med_hold_in;
      quo_ff      <= quo_in;
      out_data_ff <= out_data_in;
      out_flag_ff <= out_flag_in;
   end

endmodule

// ===== src/adc_median_trimmed_mean.sv =====
// Top level: median filter per frame with a trimmed mean over a set of medians.
//
//   port group | direction | tdata / data               | tlast     | tuser
//   req_       | in        | [11:0] sample, [15:12] chan | frame_end | discard_frame
//   rsp_       | out       | [11:0] median, [23:12] avg  | -         | average_valid
//   csr_       | in        | [3:0] channel_select        | -         | -
//
// The front end takes one item per cycle while the queue has room; the sorted
// insertion cells and the median pick settle in that cycle. The back end pops
// a median when idle with its result register free; a median that closes a
// set goes through trim, multiply by the reciprocal of AVG_COUNT-2 and result
// load before the next pop. A two-entry median queue lets the front run on
// while the back end works; req_tready drops only when that queue is full.
// Synchronous reset clears counts, running set and channel_select (to 2).
module adc_median_trimmed_mean import amtm_pkg::*; #(
   parameter int ADD_COUNT = 8,
   parameter int AVG_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] sample, [15:12] channel
   input  logic                  req_tlast,   // frame_end
   input  logic                  req_tuser,   // discard_frame
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] median, [23:12] average
   output logic                  rsp_tuser,   // average_valid
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CHAN_W-1:0]     csr_data     // channel_select
);

   queue_status_type    q_status;
   median_push_type     push;
   logic                pop;
   logic [SAMPLE_W-1:0] pop_median;

   amtm_front #(
      .ADD_COUNT (ADD_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push       (push)
   );

   amtm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .pop_median (pop_median),
      .q_status   (q_status)
   );

   amtm_back #(
      .AVG_COUNT (AVG_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_median (pop_median),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== src/amtm_checker.sv =====
// Port checker for the median / trimmed-mean filter and its bind to the top level.
module amtm_checker import amtm_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  csr_ready
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Average field stays zero unless flagged
   a_avg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[RSP_DATA_W-1:SAMPLE_W] == '0)
      else $error("average nonzero without average_valid");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   // Empty queue after reset takes items at once
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready && csr_ready)
      else $error("not ready after reset");

endmodule

bind adc_median_trimmed_mean amtm_checker u_amtm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_ready  (csr_ready)
);
